// ----- rtl/core/hsvrgb_pkg.sv -----
// Shared types, constants and helper functions for the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsvrgb_pkg;

   localparam int unsigned HUE_W    = 9;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned SECTOR_W = 3;
   localparam int unsigned OFFSET_W = 6;
   localparam int unsigned PROD_W   = 16;
   localparam int unsigned NUM_W    = 24;

   localparam logic [HUE_W-1:0] HUE_MAX = 9'd359;
   localparam logic [CHAN_W-1:0] FULL   = 8'hFF;
   localparam logic [PROD_W-1:0] FULL_SQ = 16'd65025;

   // offset * 64 / 15 == (offset * 4370) >> 10 for offsets 0..59
   localparam logic [12:0] REM_RECIP = 13'd4370;
   localparam int unsigned REM_PROD_W = OFFSET_W + 13;
   localparam int unsigned REM_SHIFT  = 10;

   // x / 65025 == (x * ceil(2^40 / 65025)) >> 40 for x up to 255 * 65025
   localparam logic [24:0] LEVEL_RECIP = 25'd16909061;
   localparam int unsigned LEVEL_PROD_W = NUM_W + 25;
   localparam int unsigned LEVEL_SHIFT  = 40;

   localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW    = 3'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN  = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN    = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE     = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA  = 3'd4;
   localparam logic [SECTOR_W-1:0] SECTOR_MAGENTA_RED   = 3'd5;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [CHAN_W-1:0]   rem;
      logic [CHAN_W-1:0]   sat;
      logic [CHAN_W-1:0]   val;
   } hue_word_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [CHAN_W-1:0]   val;
      logic [CHAN_W-1:0]   p;
      logic [CHAN_W-1:0]   q;
      logic [CHAN_W-1:0]   t;
   } level_word_type;

   function automatic logic [SECTOR_W-1:0] hue_sector(input logic [HUE_W-1:0] h);
      logic [SECTOR_W-1:0] sec;
      if (h >= 9'd300) begin
         sec = SECTOR_MAGENTA_RED;
      end else if (h >= 9'd240) begin
         sec = SECTOR_BLUE_MAGENTA;
      end else if (h >= 9'd180) begin
         sec = SECTOR_CYAN_BLUE;
      end else if (h >= 9'd120) begin
         sec = SECTOR_GREEN_CYAN;
      end else if (h >= 9'd60) begin
         sec = SECTOR_YELLOW_GREEN;
      end else begin
         sec = SECTOR_RED_YELLOW;
      end
      return sec;
   endfunction

   function automatic logic [HUE_W-1:0] sector_base(input logic [SECTOR_W-1:0] sec);
      logic [HUE_W-1:0] base;
      case (sec)
         SECTOR_RED_YELLOW:   base = 9'd0;
         SECTOR_YELLOW_GREEN: base = 9'd60;
         SECTOR_GREEN_CYAN:   base = 9'd120;
         SECTOR_CYAN_BLUE:    base = 9'd180;
         SECTOR_BLUE_MAGENTA: base = 9'd240;
         default:             base = 9'd300;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hsvrgb_sector.sv -----
// Hue front end: clamp, sector split and scaled in-sector remainder (two stages).
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_sector
   import hsvrgb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [HUE_W-1:0]   hue,
   input  wire logic [CHAN_W-1:0]  sat,
   input  wire logic [CHAN_W-1:0]  val,
   output logic                    out_valid,
   output hue_word_type            out_word
);

   logic [HUE_W-1:0]      hue_clamped;
   logic [SECTOR_W-1:0]   sector_in;
   logic [HUE_W-1:0]      offset_full;

   logic                  valid1_ff;
   logic [SECTOR_W-1:0]   sector1_ff;
   logic [OFFSET_W-1:0]   offset1_ff;
   logic [CHAN_W-1:0]     sat1_ff;
   logic [CHAN_W-1:0]     val1_ff;

   logic [REM_PROD_W-1:0] rem_prod;
   hue_word_type          word_in;
   logic                  valid2_ff;
   hue_word_type          word2_ff;

   // stage 1: saturate hue, find sector and offset within it
   always_comb begin
      hue_clamped = (hue > HUE_MAX) ? HUE_MAX : hue;
      sector_in   = hue_sector(hue_clamped);
      offset_full = hue_clamped - sector_base(sector_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sector1_ff <= sector_in;
      offset1_ff <= offset_full[OFFSET_W-1:0];
      sat1_ff    <= sat;
      val1_ff    <= val;
   end

   // stage 2: scale offset 0..59 to 0..251
   always_comb begin
      rem_prod       = REM_PROD_W'(offset1_ff) * REM_PROD_W'(REM_RECIP);
      word_in.sector = sector1_ff;
      word_in.rem    = rem_prod[REM_SHIFT +: CHAN_W];
      word_in.sat    = sat1_ff;
      word_in.val    = val1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      word2_ff <= word_in;
   end

   assign out_valid = valid2_ff;
   assign out_word  = word2_ff;

endmodule

`default_nettype wire

// ----- rtl/core/hsvrgb_levels.sv -----
// Level arithmetic: p, q and t from saturation, value and remainder (three stages).
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_levels
   import hsvrgb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  hue_word_type in_word,
   output logic         out_valid,
   output level_word_type out_word
);

   logic [PROD_W-1:0]       sq_in, st_in, pn_in;
   logic                    valid3_ff;
   logic [SECTOR_W-1:0]     sector3_ff;
   logic [CHAN_W-1:0]       val3_ff;
   logic [PROD_W-1:0]       sq3_ff, st3_ff, pn3_ff;

   logic [NUM_W-1:0]        qn_in, tn_in;
   logic [PROD_W:0]         p_sum;
   logic                    valid4_ff;
   logic [SECTOR_W-1:0]     sector4_ff;
   logic [CHAN_W-1:0]       val4_ff;
   logic [CHAN_W-1:0]       p4_ff;
   logic [NUM_W-1:0]        qn4_ff, tn4_ff;

   logic [LEVEL_PROD_W-1:0] q_prod, t_prod;
   level_word_type          word_in;
   logic                    valid5_ff;
   level_word_type          word5_ff;

   // stage 3: the three 8x8 products
   always_comb begin
      sq_in = PROD_W'(in_word.sat) * PROD_W'(in_word.rem);
      st_in = PROD_W'(in_word.sat) * PROD_W'(FULL - in_word.rem);
      pn_in = PROD_W'(in_word.val) * PROD_W'(FULL - in_word.sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sector3_ff <= in_word.sector;
      val3_ff    <= in_word.val;
      sq3_ff     <= sq_in;
      st3_ff     <= st_in;
      pn3_ff     <= pn_in;
   end

   // stage 4: scale by value; divide p by 255 with the add-and-shift identity
   always_comb begin
      qn_in = NUM_W'(val3_ff) * NUM_W'(FULL_SQ - sq3_ff);
      tn_in = NUM_W'(val3_ff) * NUM_W'(FULL_SQ - st3_ff);
      p_sum = (PROD_W+1)'(pn3_ff) + (PROD_W+1)'(pn3_ff >> CHAN_W) + (PROD_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else begin
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      sector4_ff <= sector3_ff;
      val4_ff    <= val3_ff;
      p4_ff      <= p_sum[CHAN_W +: CHAN_W];
      qn4_ff     <= qn_in;
      tn4_ff     <= tn_in;
   end

   // stage 5: divide by 65025 through the reciprocal
   always_comb begin
      q_prod         = LEVEL_PROD_W'(qn4_ff) * LEVEL_PROD_W'(LEVEL_RECIP);
      t_prod         = LEVEL_PROD_W'(tn4_ff) * LEVEL_PROD_W'(LEVEL_RECIP);
      word_in.sector = sector4_ff;
      word_in.val    = val4_ff;
      word_in.p      = p4_ff;
      word_in.q      = q_prod[LEVEL_SHIFT +: CHAN_W];
      word_in.t      = t_prod[LEVEL_SHIFT +: CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid5_ff <= 1'b0;
      end else begin
         valid5_ff <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      word5_ff <= word_in;
   end

   assign out_valid = valid5_ff;
   assign out_word  = word5_ff;

endmodule

`default_nettype wire

// ----- rtl/core/hsv_to_rgb_converter.sv -----
// Top level of the HSV to RGB converter: front end, level pipeline, channel select.
`timescale 1ns / 1ps
`default_nettype none

// Six-stage pipeline taking one word per clock: busy stays low, so a word is
// taken at every edge where start is high, and its colour appears on rsp_red,
// rsp_green and rsp_blue when it leaves the last stage, with rsp_valid high
// for one cycle. The receiver cannot hold results off; it must take each word
// in the cycle that rsp_valid marks. The stages in order: hue split,
// remainder scaling, the 8x8 products, the value scaling and the 24x25
// reciprocal multiply, then the channel select register. Hue above 359 is
// treated as 359; zero saturation yields grey (all channels equal brightness)
// through the same arithmetic.
module hsv_to_rgb_converter
   import hsvrgb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [HUE_W-1:0]  req_hue,
   input  wire logic [CHAN_W-1:0] req_saturation,
   input  wire logic [CHAN_W-1:0] req_brightness,
   output logic                   rsp_valid,
   output logic [CHAN_W-1:0]      rsp_red,
   output logic [CHAN_W-1:0]      rsp_green,
   output logic [CHAN_W-1:0]      rsp_blue
);

   logic           req_accept;
   logic           hue_valid;
   hue_word_type   hue_word;
   logic           level_valid;
   level_word_type level_word;

   logic [CHAN_W-1:0] red_in, green_in, blue_in;
   logic              valid6_ff;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;

   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   hsvrgb_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .hue       (req_hue),
      .sat       (req_saturation),
      .val       (req_brightness),
      .out_valid (hue_valid),
      .out_word  (hue_word)
   );

   hsvrgb_levels u_levels (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hue_valid),
      .in_word   (hue_word),
      .out_valid (level_valid),
      .out_word  (level_word)
   );

   // stage 6: route levels to channels by sector
   always_comb begin
      case (level_word.sector)
         SECTOR_RED_YELLOW: begin
            red_in = level_word.val; green_in = level_word.t; blue_in = level_word.p;
         end
         SECTOR_YELLOW_GREEN: begin
            red_in = level_word.q; green_in = level_word.val; blue_in = level_word.p;
         end
         SECTOR_GREEN_CYAN: begin
            red_in = level_word.p; green_in = level_word.val; blue_in = level_word.t;
         end
         SECTOR_CYAN_BLUE: begin
            red_in = level_word.p; green_in = level_word.q; blue_in = level_word.val;
         end
         SECTOR_BLUE_MAGENTA: begin
            red_in = level_word.t; green_in = level_word.p; blue_in = level_word.val;
         end
         default: begin
            red_in = level_word.val; green_in = level_word.p; blue_in = level_word.q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid6_ff <= 1'b0;
      end else begin
         valid6_ff <= level_valid;
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid = valid6_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##6 rsp_valid)
      else $error("accepted word did not come out after six cycles");

   a_grey: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_saturation == '0)) |->
         ##6 ((rsp_red == rsp_green) && (rsp_green == rsp_blue)))
      else $error("zero saturation did not give grey");

   a_peak: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##6 ((rsp_red == $past(req_brightness, 6)) ||
                          (rsp_green == $past(req_brightness, 6)) ||
                          (rsp_blue == $past(req_brightness, 6))))
      else $error("no channel carries the brightness");

endmodule

`default_nettype wire
